// ===== hw/rtl/bblur_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 clamped box blur.
// No dependencies; the front end, queue, back end and top level refer to this package by scope.
package bblur_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [11:0] FW_RESET = 12'd640;
	localparam logic [12:0] FH_RESET = 13'd480;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 17;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} column_t;

	typedef struct packed {
		logic wr;
		logic out_en;
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bot_ok;
		logic last;
	} op_flags_t;

	localparam int PIX_W  = $bits(pixel_t);
	localparam int FLAG_W = $bits(op_flags_t);

endpackage

// ===== hw/rtl/bblur_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, frame position tracking and op classification.
// Depends on bblur_pkg; feeds bblur_queue.
module bblur_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 4096,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WB = CW + 1,
	localparam int RB = $clog2(MAX_HEIGHT + 2)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                cmd,
	input  bblur_pkg::pixel_t                   pix,
	input  logic                                q_full,
	output logic                                push,
	output logic [CW-1:0]                       push_col,
	output bblur_pkg::pixel_t                   push_pix,
	output bblur_pkg::op_flags_t                push_flags
);

	logic [11:0]  fw_q;
	logic [12:0]  fh_q;
	logic [WB-1:0] eff_w;
	logic [RB-1:0] eff_h;
	logic [CW-1:0] col_q;
	logic [RB-1:0] row_q;
	logic          rcvd_q;
	logic          prime_q;
	logic          jz;
	logic          col_wrap;
	logic [CW-1:0] col_nx;
	logic [RB-1:0] row_nx;
	logic          accept;
	logic          keep;
	bblur_pkg::op_flags_t fl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bblur_pkg::FW_RESET;
			fh_q <= bblur_pkg::FH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bblur_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data[11:0];
				bblur_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0) begin
			eff_w = WB'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			eff_w = WB'(MAX_WIDTH);
		end else begin
			eff_w = WB'(fw_q);
		end
		if (fh_q == '0) begin
			eff_h = RB'(1);
		end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
			eff_h = RB'(MAX_HEIGHT);
		end else begin
			eff_h = RB'(fh_q);
		end
	end

	always_comb begin
		jz          = (col_q == '0);
		fl.wr       = !prime_q && (cmd == bblur_pkg::CMD_PIXEL);
		fl.out_en   = jz ? (row_q >= RB'(2)) : (row_q >= RB'(1));
		fl.top_ok   = jz ? (row_q >= RB'(3)) : (row_q >= RB'(2));
		fl.bot_ok   = jz ? (row_q < eff_h + RB'(1)) : (row_q < eff_h);
		fl.left_ok  = jz ? (eff_w >= WB'(2)) : (col_q >= CW'(2));
		fl.right_ok = !jz;
		fl.last     = !prime_q && (cmd == bblur_pkg::CMD_DRAIN) && jz
			&& (row_q == eff_h + RB'(1));
		col_wrap    = (({1'b0, col_q} + WB'(1)) == eff_w);
		col_nx      = col_wrap ? '0 : col_q + CW'(1);
		row_nx      = col_wrap ? row_q + RB'(1) : row_q;
	end

	assign item_ready = !q_full && !prime_q;
	assign accept     = item_valid && item_ready;
	assign keep       = accept && ((cmd == bblur_pkg::CMD_PIXEL) ? !rcvd_q : rcvd_q);
	assign push       = keep || (prime_q && !q_full);
	assign push_col   = col_q;
	assign push_pix   = pix;
	assign push_flags = fl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			rcvd_q  <= 1'b0;
			prime_q <= 1'b0;
		end else if (cfg_we) begin
			col_q   <= '0;
			row_q   <= '0;
			rcvd_q  <= 1'b0;
			prime_q <= 1'b0;
		end else if (prime_q) begin
			if (!q_full) begin
				col_q   <= col_nx;
				row_q   <= row_nx;
				prime_q <= 1'b0;
			end
		end else if (keep) begin
			if (cmd == bblur_pkg::CMD_PIXEL) begin
				col_q <= col_nx;
				row_q <= row_nx;
				if (col_wrap && (row_nx == eff_h)) begin
					rcvd_q  <= 1'b1;
					prime_q <= (eff_h == RB'(1));
				end
			end else if (fl.last) begin
				col_q  <= '0;
				row_q  <= '0;
				rcvd_q <= 1'b0;
			end else begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
		end
	end

endmodule

// ===== hw/rtl/bblur_queue.sv =====
`timescale 1ns / 1ps
// Short op queue between the front end and the back end.
// Depends on bblur_pkg for its depth.
module bblur_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);

	localparam int AW    = bblur_pkg::Q_AW;
	localparam int CNT_W = AW + 1;

	logic [DW-1:0]    mem_q [bblur_pkg::Q_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(bblur_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/bblur_back.sv =====
`timescale 1ns / 1ps
// Back end: line buffers, 3x3 window, masked sums and rounded mean by reciprocal.
// Depends on bblur_pkg; pops ops from bblur_queue and drives the result channel.
module bblur_back #(
	parameter int MAX_WIDTH = 2048,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int DW = CW + bblur_pkg::PIX_W + bblur_pkg::FLAG_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  logic [DW-1:0] q_data,
	output logic          q_pop,
	output logic          result_valid,
	input  logic          result_ready,
	output logic [7:0]    red_out,
	output logic [7:0]    green_out,
	output logic [7:0]    blue_out,
	output logic          frame_last
);

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	function automatic logic [7:0] chan(bblur_pkg::pixel_t p, logic [1:0] ch);
		logic [7:0] v;
		case (ch)
			CH_RED:   v = p.red;
			CH_GREEN: v = p.green;
			CH_BLUE:  v = p.blue;
			default:  v = p.blue;
		endcase
		return v;
	endfunction

	function automatic logic [9:0] col_sum(bblur_pkg::column_t c, logic [1:0] ch,
			logic top_ok, logic bot_ok, logic col_ok);
		logic [9:0] s;
		s = 10'(chan(c.mid, ch));
		if (top_ok) begin
			s = s + 10'(chan(c.top, ch));
		end
		if (bot_ok) begin
			s = s + 10'(chan(c.bot, ch));
		end
		if (!col_ok) begin
			s = '0;
		end
		return s;
	endfunction

	// ceil(2^17 / 2n) for each cell count n
	function automatic logic [bblur_pkg::RECIP_W-1:0] recip(logic [3:0] n);
		logic [bblur_pkg::RECIP_W-1:0] m;
		case (n)
			4'd1:    m = 17'd65536;
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd6:    m = 17'd10923;
			4'd9:    m = 17'd7282;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

	logic                  adv;
	logic [CW-1:0]         q_col;
	bblur_pkg::pixel_t     q_pix;
	bblur_pkg::op_flags_t  q_fl;
	logic                  wr_en;
	logic                  fwd;

	bblur_pkg::pixel_t     older_mem [MAX_WIDTH];
	bblur_pkg::pixel_t     newer_mem [MAX_WIDTH];

	logic                  v_s1;
	logic [CW-1:0]         col_s1;
	bblur_pkg::pixel_t     pix_s1;
	bblur_pkg::op_flags_t  fl_s1;
	bblur_pkg::pixel_t     rd_old_s1;
	bblur_pkg::pixel_t     rd_new_s1;
	bblur_pkg::column_t    n_col;
	bblur_pkg::column_t    win_l_q;
	bblur_pkg::column_t    win_m_q;

	logic                  v_s2;
	logic                  last_s2;
	logic [1:0]            rows_s2;
	logic [1:0]            cols_s2;
	logic [9:0]            csum_s2 [3][3];

	logic [11:0]           total [3];
	logic [3:0]            n_cells;

	logic                  v_s3;
	logic                  last_s3;
	logic [12:0]           x_s3 [3];
	logic [bblur_pkg::RECIP_W-1:0] m_s3;

	logic [29:0]           prod [3];

	logic                  res_vld_q;
	logic [7:0]            red_q;
	logic [7:0]            green_q;
	logic [7:0]            blue_q;
	logic                  last_q;

	assign adv   = !res_vld_q || result_ready;
	assign q_pop = adv && !q_empty;

	assign q_col = q_data[DW-1 -: CW];
	assign q_pix = bblur_pkg::pixel_t'(q_data[bblur_pkg::FLAG_W +: bblur_pkg::PIX_W]);
	assign q_fl  = bblur_pkg::op_flags_t'(q_data[bblur_pkg::FLAG_W-1:0]);

	assign wr_en = adv && v_s1 && fl_s1.wr;
	assign fwd   = wr_en && (col_s1 == q_col);
	assign n_col = {rd_old_s1, rd_new_s1, pix_s1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[col_s1] <= rd_new_s1;
			newer_mem[col_s1] <= pix_s1;
		end
		if (q_pop) begin
			rd_old_s1 <= fwd ? rd_new_s1 : older_mem[q_col];
			rd_new_s1 <= fwd ? pix_s1 : newer_mem[q_col];
			col_s1    <= q_col;
			pix_s1    <= q_pix;
			fl_s1     <= q_fl;
		end
	end

	always_comb begin
		n_cells = 4'(rows_s2) * 4'(cols_s2);
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = 12'(csum_s2[0][ch]) + 12'(csum_s2[1][ch]) + 12'(csum_s2[2][ch]);
			prod[ch]  = 30'(x_s3[ch]) * 30'(m_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s1) begin
				win_l_q <= win_m_q;
				win_m_q <= n_col;
			end
			last_s2 <= fl_s1.last;
			rows_s2 <= 2'd1 + 2'(fl_s1.top_ok) + 2'(fl_s1.bot_ok);
			cols_s2 <= 2'd1 + 2'(fl_s1.left_ok) + 2'(fl_s1.right_ok);
			for (int ch = 0; ch < 3; ch++) begin
				csum_s2[0][ch] <= col_sum(win_l_q, 2'(ch), fl_s1.top_ok, fl_s1.bot_ok,
					fl_s1.left_ok);
				csum_s2[1][ch] <= col_sum(win_m_q, 2'(ch), fl_s1.top_ok, fl_s1.bot_ok, 1'b1);
				csum_s2[2][ch] <= col_sum(n_col, 2'(ch), fl_s1.top_ok, fl_s1.bot_ok,
					fl_s1.right_ok);
				x_s3[ch] <= 13'({total[ch], 1'b0}) + 13'(n_cells);
			end
			m_s3    <= recip(n_cells);
			last_s3 <= last_s2;
			red_q   <= prod[0][bblur_pkg::RECIP_SHIFT +: 8];
			green_q <= prod[1][bblur_pkg::RECIP_SHIFT +: 8];
			blue_q  <= prod[2][bblur_pkg::RECIP_SHIFT +: 8];
			last_q  <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= q_pop;
			v_s2      <= v_s1 && fl_s1.out_en;
			v_s3      <= v_s2;
			res_vld_q <= v_s3;
		end
	end

	assign result_valid = res_vld_q;
	assign red_out      = red_q;
	assign green_out    = green_q;
	assign blue_out     = blue_q;
	assign frame_last   = last_q;

endmodule

// ===== hw/rtl/box_blur_3x3_clamped.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 clamped box blur: front end, op queue and back end.
// Depends on bblur_pkg, bblur_front, bblur_queue and bblur_back.
// Feed pixels in raster order with cmd low; each output pixel is the per-channel mean of its
// in-frame 3x3 neighbourhood (divisor 1, 2, 3, 4, 6 or 9), rounded to nearest with halves up.
// Output pixel k is released by input pixel k+W+1; after the last pixel of the frame, send
// drain items (cmd high) to flush the remaining W+1 pixels (W for a one-row frame), one per
// item, the final one flagged by frame_last. Pixels after a full frame and drains before it
// are dropped. The block takes one item per clock while its queue has room and no priming
// step is pending: a four-entry queue separates the front end from a back pipeline of
// line-buffer read, column sums, total with rounding offset, and reciprocal multiply into
// the output register, which offers a result once its releasing item has passed the queue
// and these stages; a stalled result stalls the back pipeline and the front end keeps
// taking items until the queue fills. A one-row frame holds off the next item after its
// last pixel for an internal priming step. Writing either size register restarts the frame.
module box_blur_3x3_clamped #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             cmd,
	input  logic [7:0]                       red_in,
	input  logic [7:0]                       green_in,
	input  logic [7:0]                       blue_in,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [7:0]                       red_out,
	output logic [7:0]                       green_out,
	output logic [7:0]                       blue_out,
	output logic                             frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int DW = CW + bblur_pkg::PIX_W + bblur_pkg::FLAG_W;

	bblur_pkg::pixel_t    pix;
	logic                 q_full;
	logic                 q_empty;
	logic                 push;
	logic                 q_pop;
	logic [CW-1:0]        push_col;
	bblur_pkg::pixel_t    push_pix;
	bblur_pkg::op_flags_t push_flags;
	logic [DW-1:0]        q_wdata;
	logic [DW-1:0]        q_rdata;

	assign pix.red   = red_in;
	assign pix.green = green_in;
	assign pix.blue  = blue_in;
	assign q_wdata   = {push_col, push_pix, push_flags};

	bblur_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.cmd       (cmd),
		.pix       (pix),
		.q_full    (q_full),
		.push      (push),
		.push_col  (push_col),
		.push_pix  (push_pix),
		.push_flags(push_flags)
	);

	bblur_queue #(
		.DW(DW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	bblur_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.frame_last  (frame_last)
	);

endmodule

// ===== hw/rtl/bblur_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the 3x3 clamped box blur.
// Bound to box_blur_3x3_clamped; no other dependencies.
module bblur_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       frame_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(frame_last))
		else $error("result changed while stalled");

	a_frame_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && frame_last |=> !result_valid)
		else $error("result right after the last item of a frame");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result offered during reset");

endmodule

bind box_blur_3x3_clamped bblur_checker u_bblur_checker (.*);
